### sv/lambert_diffuse_light_defines.svh
// assertion macros shared by the lambert diffuse light block
`ifndef LAMBERT_DIFFUSE_LIGHT_DEFINES_SVH
`define LAMBERT_DIFFUSE_LIGHT_DEFINES_SVH

// condition implies a property in the same cycle
`define LDL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies a property in the following cycle
`define LDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ldl_pkg.sv
// shared types, widths and codes for the lambert diffuse light block
package ldl_pkg;

    // fixed point formats
    localparam int VEC_FRAC_BITS = 14;
    localparam int N_W       = 16;
    localparam int C_W       = 32;
    localparam int L_W       = C_W + 1;
    localparam int MAG_W     = 30;
    localparam int LEN2_W    = 2 * MAG_W + 2;
    localparam int LEN_W     = MAG_W + 1;
    localparam int REM_W     = LEN2_W + 1;
    localparam int Q_W       = VEC_FRAC_BITS + 1;
    localparam int U_W       = VEC_FRAC_BITS + 2;
    localparam int NUM_W     = MAG_W + VEC_FRAC_BITS + 1;
    localparam int REG_IDX_W = 3;

    // light modes
    localparam logic [2:0] MODE_NONE       = 3'd0;
    localparam logic [2:0] MODE_DIR        = 3'd1;
    localparam logic [2:0] MODE_DIR_CONE   = 3'd2;
    localparam logic [2:0] MODE_POINT      = 3'd3;
    localparam logic [2:0] MODE_POINT_CONE = 3'd4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POS_X  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POS_Y  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POS_Z  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Z = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COS    = 3'd7;

    localparam logic [N_W-1:0] COS_RESET = 16'd16384;

    typedef struct packed {
        logic [N_W-1:0] normal_x;
        logic [N_W-1:0] normal_y;
        logic [N_W-1:0] normal_z;
        logic [C_W-1:0] point_x;
        logic [C_W-1:0] point_y;
        logic [C_W-1:0] point_z;
        logic [C_W-1:0] light_red;
        logic [C_W-1:0] light_green;
        logic [C_W-1:0] light_blue;
        logic [C_W-1:0] sum_red;
        logic [C_W-1:0] sum_green;
        logic [C_W-1:0] sum_blue;
    } in_t;

    typedef struct packed {
        logic [C_W-1:0] out_red;
        logic [C_W-1:0] out_green;
        logic [C_W-1:0] out_blue;
    } out_t;

    // configuration registers, lane 0 is x
    typedef struct packed {
        logic [2:0]            mode;
        logic [2:0][C_W-1:0]   pos;
        logic [2:0][N_W-1:0]   axis;
        logic [N_W-1:0]        cosine;
    } cfg_t;

    // per item data carried down the pipeline up to the first shade stage
    typedef struct packed {
        logic                pt;
        logic                pt_cone;
        logic                kill;
        logic [2:0]          neg;
        logic [2:0][N_W-1:0] n;
        logic [2:0][C_W-1:0] cl;
        logic [2:0][C_W-1:0] sum;
    } side_t;

    typedef struct packed {
        side_t                 side;
        logic [2:0][MAG_W-1:0] mag;
        logic [LEN2_W-1:0]     len2;
    } norm_t;

    typedef struct packed {
        side_t                 side;
        logic [2:0][MAG_W-1:0] mag;
        logic [LEN_W-1:0]      len;
    } lenv_t;

    typedef struct packed {
        side_t               side;
        logic [2:0][U_W-1:0] u;
    } unit_t;

endpackage

### sv/ldl_vec.sv
// light vector, magnitude scaling, directional tests and squared length
module ldl_vec (
    input  logic          clk,
    input  logic          rst_n,
    input  ldl_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  ldl_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ldl_pkg::norm_t out_data
);
    import ldl_pkg::*;

    localparam int PNL_W = N_W + L_W;
    localparam int PAN_W = 2 * N_W;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int DNL_W = PNL_W + 2;
    localparam int DAN_W = PAN_W + 2;
    localparam int CMP_W = DAN_W + 2;

    typedef struct packed {
        side_t               side;
        logic                dir;
        logic                dcone;
        logic [2:0][L_W-1:0] l;
    } sa_t;

    typedef struct packed {
        side_t                 side;
        logic                  dir;
        logic                  dcone;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0][PNL_W-1:0] pnl;
        logic [2:0][PAN_W-1:0] pan;
    } sb_t;

    typedef struct packed {
        side_t                 side;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0][SQ_W-1:0]  sq;
    } sc_t;

    sa_t   sa_next, sa_reg;
    sb_t   sb_next, sb_reg;
    sc_t   sc_next, sc_reg;
    norm_t sd_next, sd_reg;
    logic  va_reg, vb_reg, vc_reg, vd_reg;
    logic  en_a, en_b, en_c, en_d;

    logic [2:0][C_W-1:0] pnt;
    assign pnt = {in_data.point_z, in_data.point_y, in_data.point_x};

    // ready chain, a stage moves when empty or when the next one moves
    assign en_d     = !vd_reg || out_ready;
    assign en_c     = !vc_reg || en_d;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // stage a: light vector
    always_comb
    begin
        logic signed [L_W-1:0] lp;
        logic signed [L_W-1:0] lv;
        logic                  dir;
        logic                  pt;
        dir = (cfg.mode == MODE_DIR) || (cfg.mode == MODE_DIR_CONE);
        pt  = (cfg.mode == MODE_POINT) || (cfg.mode == MODE_POINT_CONE);
        sa_next.dir          = dir;
        sa_next.dcone        = (cfg.mode == MODE_DIR_CONE);
        sa_next.side.pt      = pt;
        sa_next.side.pt_cone = (cfg.mode == MODE_POINT_CONE);
        sa_next.side.kill    = !(dir || pt);
        sa_next.side.n   = {in_data.normal_z, in_data.normal_y, in_data.normal_x};
        sa_next.side.cl  = {in_data.light_blue, in_data.light_green, in_data.light_red};
        sa_next.side.sum = {in_data.sum_blue, in_data.sum_green, in_data.sum_red};
        for (int i = 0; i < 3; i++)
        begin
            lp = L_W'($signed(cfg.pos[i]));
            if (pt)
            begin
                lv = lp - L_W'($signed(pnt[i]));
            end
            else
            begin
                lv = -lp;
            end
            sa_next.l[i]        = lv;
            sa_next.side.neg[i] = lv[L_W-1];
        end
    end

    // stage b: magnitudes scaled below 2^30, dot products for directional tests
    always_comb
    begin
        logic [L_W-1:0] mag_full [3];
        logic [L_W-1:0] mag_or;
        logic [1:0]     sh;
        for (int i = 0; i < 3; i++)
        begin
            mag_full[i] = sa_reg.l[i][L_W-1] ? L_W'(-$signed(sa_reg.l[i])) : sa_reg.l[i];
        end
        mag_or = mag_full[0] | mag_full[1] | mag_full[2];
        if (mag_or[MAG_W+2])
        begin
            sh = 2'd3;
        end
        else if (mag_or[MAG_W+1])
        begin
            sh = 2'd2;
        end
        else if (mag_or[MAG_W])
        begin
            sh = 2'd1;
        end
        else
        begin
            sh = 2'd0;
        end
        sb_next.side  = sa_reg.side;
        sb_next.dir   = sa_reg.dir;
        sb_next.dcone = sa_reg.dcone;
        for (int i = 0; i < 3; i++)
        begin
            sb_next.mag[i] = MAG_W'(mag_full[i] >> sh);
            sb_next.pnl[i] = $signed(sa_reg.side.n[i]) * $signed(sa_reg.l[i]);
            sb_next.pan[i] = $signed(cfg.axis[i]) * $signed(sa_reg.side.n[i]);
        end
    end

    // stage c: squares, lit and cone decision for directional lights
    always_comb
    begin
        logic signed [DNL_W-1:0] dnl;
        logic signed [DAN_W-1:0] dan;
        logic signed [CMP_W-1:0] neg_dan;
        logic signed [CMP_W-1:0] cosq;
        dnl = DNL_W'($signed(sb_reg.pnl[0])) + DNL_W'($signed(sb_reg.pnl[1]))
            + DNL_W'($signed(sb_reg.pnl[2]));
        dan = DAN_W'($signed(sb_reg.pan[0])) + DAN_W'($signed(sb_reg.pan[1]))
            + DAN_W'($signed(sb_reg.pan[2]));
        neg_dan = -CMP_W'(dan);
        cosq    = CMP_W'($signed(cfg.cosine)) <<< VEC_FRAC_BITS;
        sc_next.side = sb_reg.side;
        sc_next.side.kill = sb_reg.side.kill ||
            (sb_reg.dir && ((dnl < 0) || (sb_reg.dcone && (neg_dan < cosq))));
        sc_next.mag = sb_reg.mag;
        for (int i = 0; i < 3; i++)
        begin
            sc_next.sq[i] = sb_reg.mag[i] * sb_reg.mag[i];
        end
    end

    // stage d: squared length
    always_comb
    begin
        sd_next.side = sc_reg.side;
        sd_next.mag  = sc_reg.mag;
        sd_next.len2 = LEN2_W'(sc_reg.sq[0]) + LEN2_W'(sc_reg.sq[1])
                     + LEN2_W'(sc_reg.sq[2]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
            if (en_d) vd_reg <= vc_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en_a) sa_reg <= sa_next;
        if (en_b) sb_reg <= sb_next;
        if (en_c) sc_reg <= sc_next;
        if (en_d) sd_reg <= sd_next;
    end

    assign out_valid = vd_reg;
    assign out_data  = sd_reg;

endmodule

### sv/ldl_sqrt.sv
// pipelined integer square root, one result bit per stage
module ldl_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ldl_pkg::norm_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ldl_pkg::lenv_t out_data
);
    import ldl_pkg::*;

    typedef struct packed {
        side_t                 side;
        logic [2:0][MAG_W-1:0] mag;
        logic [LEN_W-1:0]      root;
        logic [REM_W-1:0]      rem;
    } sq_t;

    sq_t              src    [LEN_W];
    sq_t              nxt    [LEN_W];
    sq_t              st_reg [LEN_W];
    logic [LEN_W-1:0] v_reg;
    logic [LEN_W-1:0] src_v;
    logic [LEN_W:0]   en;

    // stage sources
    always_comb
    begin
        src[0].side = in_data.side;
        src[0].mag  = in_data.mag;
        src[0].root = '0;
        src[0].rem  = REM_W'(in_data.len2);
        src_v[0]    = in_valid;
        for (int s = 1; s < LEN_W; s++)
        begin
            src[s]   = st_reg[s-1];
            src_v[s] = v_reg[s-1];
        end
    end

    // one root bit per stage, highest bit first
    always_comb
    begin
        logic [REM_W-1:0] trial;
        for (int s = 0; s < LEN_W; s++)
        begin
            nxt[s] = src[s];
            trial  = (REM_W'(src[s].root) << (LEN_W - s))
                   + (REM_W'(1) << (2 * (LEN_W - 1 - s)));
            if (src[s].rem >= trial)
            begin
                nxt[s].rem  = src[s].rem - trial;
                nxt[s].root = src[s].root | (LEN_W'(1) << (LEN_W - 1 - s));
            end
        end
    end

    // ready chain
    always_comb
    begin
        en[LEN_W] = out_ready;
        for (int s = LEN_W - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < LEN_W; s++)
            begin
                if (en[s]) v_reg[s] <= src_v[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < LEN_W; s++)
        begin
            if (en[s]) st_reg[s] <= nxt[s];
        end
    end

    assign in_ready      = en[0];
    assign out_valid     = v_reg[LEN_W-1];
    assign out_data.side = st_reg[LEN_W-1].side;
    assign out_data.mag  = st_reg[LEN_W-1].mag;
    assign out_data.len  = st_reg[LEN_W-1].root;

endmodule

### sv/ldl_div.sv
// pipelined rounding divider giving the unit light vector, one quotient bit per stage after the first
module ldl_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ldl_pkg::lenv_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ldl_pkg::unit_t out_data
);
    import ldl_pkg::*;

    localparam int DV_N = Q_W + 1;

    typedef struct packed {
        side_t                 side;
        logic [LEN_W-1:0]      len;
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][Q_W-1:0]   q;
    } dv_t;

    dv_t             src    [DV_N];
    dv_t             nxt    [DV_N];
    dv_t             st_reg [DV_N];
    logic [DV_N-1:0] v_reg;
    logic [DV_N-1:0] src_v;
    logic [DV_N:0]   en;

    // stage sources
    always_comb
    begin
        src[0].side = in_data.side;
        src[0].len  = in_data.len;
        src[0].rem  = '0;
        src[0].q    = '0;
        src_v[0]    = in_valid;
        for (int s = 1; s < DV_N; s++)
        begin
            src[s]   = st_reg[s-1];
            src_v[s] = v_reg[s-1];
        end
    end

    // first stage forms the rounded numerator, then one quotient bit per stage
    always_comb
    begin
        logic [NUM_W-1:0] dvs;
        for (int s = 0; s < DV_N; s++)
        begin
            nxt[s] = src[s];
            dvs    = NUM_W'(src[s].len) << (Q_W - s);
            for (int i = 0; i < 3; i++)
            begin
                if (s == 0)
                begin
                    nxt[s].rem[i] = (NUM_W'(in_data.mag[i]) << VEC_FRAC_BITS)
                                  + NUM_W'(in_data.len >> 1);
                end
                else if (src[s].rem[i] >= dvs)
                begin
                    nxt[s].rem[i] = src[s].rem[i] - dvs;
                    nxt[s].q[i]   = src[s].q[i] | (Q_W'(1) << (Q_W - s));
                end
            end
        end
    end

    // ready chain
    always_comb
    begin
        en[DV_N] = out_ready;
        for (int s = DV_N - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < DV_N; s++)
            begin
                if (en[s]) v_reg[s] <= src_v[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DV_N; s++)
        begin
            if (en[s]) st_reg[s] <= nxt[s];
        end
    end

    // signed unit components, zero for a zero length vector
    always_comb
    begin
        out_data.side = st_reg[DV_N-1].side;
        for (int i = 0; i < 3; i++)
        begin
            if (st_reg[DV_N-1].len == '0)
            begin
                out_data.u[i] = '0;
            end
            else if (st_reg[DV_N-1].side.neg[i])
            begin
                out_data.u[i] = -U_W'(st_reg[DV_N-1].q[i]);
            end
            else
            begin
                out_data.u[i] = U_W'(st_reg[DV_N-1].q[i]);
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[DV_N-1];

endmodule

### sv/ldl_shade.sv
// lambert term, point light tests, color scaling and saturating add
module ldl_shade (
    input  logic           clk,
    input  logic           rst_n,
    input  ldl_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  ldl_pkg::unit_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ldl_pkg::out_t  out_data
);
    import ldl_pkg::*;

    localparam int P_W    = N_W + U_W;
    localparam int D_W    = P_W + 2;
    localparam int D1_W   = D_W + 1;
    localparam int DQ_W   = D1_W - VEC_FRAC_BITS;
    localparam int CMP_W  = D_W + 2;
    localparam int PR_W   = C_W + DQ_W;
    localparam int PR1_W  = PR_W + 1;
    localparam int TERM_W = PR1_W - VEC_FRAC_BITS;
    localparam int S_W    = TERM_W + 1;
    localparam int HALF   = 1 << (VEC_FRAC_BITS - 1);

    typedef struct packed {
        side_t               side;
        logic [2:0][P_W-1:0] pnu;
        logic [2:0][P_W-1:0] pau;
    } ta_t;

    typedef struct packed {
        logic                lit;
        logic [2:0][C_W-1:0] cl;
        logic [2:0][C_W-1:0] sum;
        logic [DQ_W-1:0]     dq;
    } tb_t;

    typedef struct packed {
        logic                 lit;
        logic [2:0][C_W-1:0]  sum;
        logic [2:0][PR_W-1:0] prod;
    } tc_t;

    ta_t  ta_next, ta_reg;
    tb_t  tb_next, tb_reg;
    tc_t  tc_next, tc_reg;
    out_t td_next, td_reg;
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic en_a, en_b, en_c, en_d;

    // ready chain
    assign en_d     = !vd_reg || out_ready;
    assign en_c     = !vc_reg || en_d;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // stage a: products with the unit vector
    always_comb
    begin
        ta_next.side = in_data.side;
        for (int i = 0; i < 3; i++)
        begin
            ta_next.pnu[i] = $signed(in_data.side.n[i]) * $signed(in_data.u[i]);
            ta_next.pau[i] = $signed(cfg.axis[i]) * $signed(in_data.u[i]);
        end
    end

    // stage b: lambert dot product, rounding and point light tests
    always_comb
    begin
        logic signed [D_W-1:0]   d;
        logic signed [D_W-1:0]   dau;
        logic signed [D1_W-1:0]  dr;
        logic signed [CMP_W-1:0] neg_dau;
        logic signed [CMP_W-1:0] cosq;
        d   = D_W'($signed(ta_reg.pnu[0])) + D_W'($signed(ta_reg.pnu[1]))
            + D_W'($signed(ta_reg.pnu[2]));
        dau = D_W'($signed(ta_reg.pau[0])) + D_W'($signed(ta_reg.pau[1]))
            + D_W'($signed(ta_reg.pau[2]));
        dr      = D1_W'(d) + D1_W'(HALF);
        neg_dau = -CMP_W'(dau);
        cosq    = CMP_W'($signed(cfg.cosine)) <<< VEC_FRAC_BITS;
        tb_next.dq  = DQ_W'(dr >>> VEC_FRAC_BITS);
        tb_next.cl  = ta_reg.side.cl;
        tb_next.sum = ta_reg.side.sum;
        tb_next.lit = !ta_reg.side.kill
                   && !(ta_reg.side.pt && (d < 0))
                   && !(ta_reg.side.pt_cone && (neg_dau < cosq));
    end

    // stage c: scale the light color
    always_comb
    begin
        tc_next.lit = tb_reg.lit;
        tc_next.sum = tb_reg.sum;
        for (int i = 0; i < 3; i++)
        begin
            tc_next.prod[i] = $signed(tb_reg.cl[i]) * $signed(tb_reg.dq);
        end
    end

    // stage d: round the term, add and saturate
    always_comb
    begin
        logic signed [PR1_W-1:0] pr;
        logic signed [S_W-1:0]   s;
        logic [2:0][C_W-1:0]     res;
        for (int i = 0; i < 3; i++)
        begin
            pr = PR1_W'($signed(tc_reg.prod[i])) + PR1_W'(HALF);
            s  = S_W'($signed(tc_reg.sum[i])) + S_W'(pr >>> VEC_FRAC_BITS);
            if (!tc_reg.lit)
            begin
                res[i] = tc_reg.sum[i];
            end
            else if ((&s[S_W-1:C_W-1]) || !(|s[S_W-1:C_W-1]))
            begin
                res[i] = s[C_W-1:0];
            end
            else if (s[S_W-1])
            begin
                res[i] = {1'b1, {(C_W-1){1'b0}}};
            end
            else
            begin
                res[i] = {1'b0, {(C_W-1){1'b1}}};
            end
        end
        td_next.out_red   = res[0];
        td_next.out_green = res[1];
        td_next.out_blue  = res[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
            if (en_d) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a) ta_reg <= ta_next;
        if (en_b) tb_reg <= tb_next;
        if (en_c) tc_reg <= tc_next;
        if (en_d) td_reg <= td_next;
    end

    assign out_valid = vd_reg;
    assign out_data  = td_reg;

endmodule

### sv/lambert_diffuse_light.sv
// lambert diffuse light: adds one light's diffuse term to a running color
// pipeline from input transaction to result: 4 front stages, 31 square root stages (one root
// bit each), 16 divider stages (numerator first, then one quotient bit each), 4 shade stages
// throughput one transaction per cycle; every stage has its own valid bit and stalls
// only when full and blocked downstream
// reset (async, active low) empties the pipeline and sets mode none and cone cosine 1.0
`include "lambert_diffuse_light_defines.svh"

module lambert_diffuse_light (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ldl_pkg::REG_IDX_W-1:0]     cfg_idx,
    input  logic [ldl_pkg::C_W-1:0]           cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ldl_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ldl_pkg::out_t                     out_data
);
    import ldl_pkg::*;

    localparam logic signed [U_W-1:0] U_ONE = U_W'(1) <<< VEC_FRAC_BITS;

    cfg_t  cfg_reg;
    logic  fv_valid, fv_ready;
    norm_t fv_data;
    logic  sq_valid, sq_ready;
    lenv_t sq_data;
    logic  dv_valid, dv_ready;
    unit_t dv_data;
    logic  unit_ok;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_NONE;
            cfg_reg.pos    <= '0;
            cfg_reg.axis   <= '0;
            cfg_reg.cosine <= COS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_MODE:   cfg_reg.mode    <= cfg_data[2:0];
                REG_POS_X:  cfg_reg.pos[0]  <= cfg_data;
                REG_POS_Y:  cfg_reg.pos[1]  <= cfg_data;
                REG_POS_Z:  cfg_reg.pos[2]  <= cfg_data;
                REG_AXIS_X: cfg_reg.axis[0] <= cfg_data[N_W-1:0];
                REG_AXIS_Y: cfg_reg.axis[1] <= cfg_data[N_W-1:0];
                REG_AXIS_Z: cfg_reg.axis[2] <= cfg_data[N_W-1:0];
                REG_COS:    cfg_reg.cosine  <= cfg_data[N_W-1:0];
                default:    cfg_reg.mode    <= cfg_reg.mode;
            endcase
        end
    end

    // light vector and squared length
    ldl_vec u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (fv_valid),
        .out_ready (fv_ready),
        .out_data  (fv_data)
    );

    // vector length
    ldl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv_valid),
        .in_ready  (fv_ready),
        .in_data   (fv_data),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data)
    );

    // normalization
    ldl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_data   (sq_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv_data)
    );

    // diffuse term and accumulation
    ldl_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_data   (dv_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // unit components never exceed one in magnitude
    always_comb
    begin
        unit_ok = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (($signed(dv_data.u[i]) > U_ONE) || ($signed(dv_data.u[i]) < -U_ONE))
            begin
                unit_ok = 1'b0;
            end
        end
    end

    `LDL_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "pipeline refused a transaction while empty at the output")
    `LDL_ASSERT_SAME(a_unit_range, dv_valid, unit_ok, "unit light vector component above one")
    `LDL_ASSERT_SAME(a_none_passes, fv_valid && (cfg_reg.mode == MODE_NONE), fv_data.side.kill, "mode none transaction not marked pass through")
    `LDL_ASSERT_NEXT(a_mode_write, cfg_we && (cfg_idx == REG_MODE), cfg_reg.mode == $past(cfg_data[2:0]), "light mode write lost")

endmodule

### sim/tb_lambert_diffuse_light.sv
// testbench for the lambert diffuse light block: directed table plus random shading points
`timescale 1ns / 100ps

module tb_lambert_diffuse_light;
    import ldl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 70;
    localparam int HOLD_CYCLES    = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [C_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    lambert_diffuse_light uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // shadow copy of the light registers
    logic [2:0]  lt_mode;
    longint      lt_pos [3];
    longint      lt_axis [3];
    longint      lt_cos;

    out_t color_fifo[$];
    int   n_errors;
    int   n_colors;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic typed_valid;
    out_t typed_color;

    // stimulus table entry
    typedef struct {
        int   cfg_sel;
        in_t  item;
        bit   has_color;
        out_t color;
    } row_t;
    row_t dir_rows[$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        n_errors++;
    endtask

    function automatic longint sext16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint sext32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // round half up then drop the vector fraction bits
    function automatic longint round_frac(longint x);
        longint y;
        y = x + (longint'(1) <<< (VEC_FRAC_BITS - 1));
        if (y >= 0)
            return y >>> VEC_FRAC_BITS;
        return -((-y + (longint'(1) <<< VEC_FRAC_BITS) - 1) >>> VEC_FRAC_BITS);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // normalize the light vector to Q2.14
    task automatic normalize(input longint c [3], output longint u [3]);
        longint unsigned mag [3];
        longint unsigned len2;
        longint unsigned len;
        longint q;
        for (int i = 0; i < 3; i++)
            mag[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
        while (mag[0] >= (64'd1 << 30) || mag[1] >= (64'd1 << 30) || mag[2] >= (64'd1 << 30))
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        len2 = 0;
        for (int i = 0; i < 3; i++)
            len2 += mag[i] * mag[i];
        len = int_sqrt(len2);
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                u[i] = 0;
            else
            begin
                q = longint'(((mag[i] << VEC_FRAC_BITS) + (len >> 1)) / len);
                u[i] = c[i] < 0 ? -q : q;
            end
        end
    endtask

    // new running color for one shading point
    task automatic shade_point(input in_t it, output out_t res);
        longint nrm [3];
        longint pt [3];
        longint cl [3];
        longint acc [3];
        longint lv [3];
        longint u [3];
        longint d;
        longint dq;
        longint s;
        bit lit;
        nrm = '{sext16(it.normal_x), sext16(it.normal_y), sext16(it.normal_z)};
        pt  = '{sext32(it.point_x), sext32(it.point_y), sext32(it.point_z)};
        cl  = '{sext32(it.light_red), sext32(it.light_green), sext32(it.light_blue)};
        acc = '{sext32(it.sum_red), sext32(it.sum_green), sext32(it.sum_blue)};
        lit = 1'b0;
        u = '{0, 0, 0};
        if (lt_mode == MODE_DIR || lt_mode == MODE_DIR_CONE)
        begin
            for (int i = 0; i < 3; i++)
                lv[i] = -lt_pos[i];
            normalize(lv, u);
            lit = (nrm[0] * lv[0] + nrm[1] * lv[1] + nrm[2] * lv[2]) >= 0;
            if (lt_mode == MODE_DIR_CONE &&
                -(lt_axis[0] * nrm[0] + lt_axis[1] * nrm[1] + lt_axis[2] * nrm[2]) <
                (lt_cos <<< VEC_FRAC_BITS))
                lit = 1'b0;
        end
        else if (lt_mode == MODE_POINT || lt_mode == MODE_POINT_CONE)
        begin
            for (int i = 0; i < 3; i++)
                lv[i] = lt_pos[i] - pt[i];
            normalize(lv, u);
            lit = (nrm[0] * u[0] + nrm[1] * u[1] + nrm[2] * u[2]) >= 0;
            if (lt_mode == MODE_POINT_CONE &&
                -(lt_axis[0] * u[0] + lt_axis[1] * u[1] + lt_axis[2] * u[2]) <
                (lt_cos <<< VEC_FRAC_BITS))
                lit = 1'b0;
        end
        if (lit)
        begin
            d  = nrm[0] * u[0] + nrm[1] * u[1] + nrm[2] * u[2];
            dq = round_frac(d);
            for (int i = 0; i < 3; i++)
            begin
                s = acc[i] + round_frac(cl[i] * dq);
                if (s > 64'sh7fffffff)
                    s = 64'sh7fffffff;
                if (s < -64'sh80000000)
                    s = -64'sh80000000;
                acc[i] = s;
            end
        end
        res.out_red   = acc[0][31:0];
        res.out_green = acc[1][31:0];
        res.out_blue  = acc[2][31:0];
    endtask

    // record expectation for each accepted input transaction
    always @(posedge clk)
    begin
        out_t c;
        if (rst_n && in_valid && in_ready)
        begin
            if (typed_valid)
                color_fifo.push_back(typed_color);
            else
            begin
                shade_point(in_data, c);
                color_fifo.push_back(c);
            end
        end
    end

    // check each output transaction
    always @(posedge clk)
    begin
        out_t w;
        if (rst_n && out_valid && out_ready)
        begin
            n_colors++;
            if (color_fifo.size() == 0)
            begin
                $display("unexpected result %h at %0t", out_data, $realtime);
                n_errors++;
            end
            else
            begin
                w = color_fifo.pop_front();
                if (w.out_red !== out_data.out_red)
                    report_mismatch("red", w.out_red, out_data.out_red);
                if (w.out_green !== out_data.out_green)
                    report_mismatch("green", w.out_green, out_data.out_green);
                if (w.out_blue !== out_data.out_blue)
                    report_mismatch("blue", w.out_blue, out_data.out_blue);
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && n_colors >= 120)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_MODE:   lt_mode = val[2:0];
            REG_POS_X:  lt_pos[0] = sext32(val);
            REG_POS_Y:  lt_pos[1] = sext32(val);
            REG_POS_Z:  lt_pos[2] = sext32(val);
            REG_AXIS_X: lt_axis[0] = sext16(val[15:0]);
            REG_AXIS_Y: lt_axis[1] = sext16(val[15:0]);
            REG_AXIS_Z: lt_axis[2] = sext16(val[15:0]);
            default:    lt_cos = sext16(val[15:0]);
        endcase
    endtask

    task automatic set_light(input logic [2:0] mode, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [15:0] cs);
        write_reg(REG_MODE, {29'd0, mode});
        write_reg(REG_POS_X, px);
        write_reg(REG_POS_Y, py);
        write_reg(REG_POS_Z, pz);
        write_reg(REG_AXIS_X, {16'd0, ax});
        write_reg(REG_AXIS_Y, {16'd0, ay});
        write_reg(REG_AXIS_Z, {16'd0, az});
        write_reg(REG_COS, {16'd0, cs});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // let the pipeline run dry before touching the registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (color_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_point(input in_t it, input bit has_c, input out_t c);
        bit acc;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_data     <= it;
        typed_valid <= has_c;
        typed_color <= c;
        do
        begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end
        while (!acc);
    endtask

    function automatic in_t mk_point(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                     logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                     logic [31:0] cl, logic [31:0] sm);
        in_t it;
        it = '{nx, ny, nz, px, py, pz, cl, cl, cl, sm, sm, sm};
        return it;
    endfunction

    task automatic add_row(input int sel, input in_t it, input bit has_c, input logic [31:0] c);
        row_t r;
        r.cfg_sel   = sel;
        r.item      = it;
        r.has_color = has_c;
        r.color     = '{c, c, c};
        dir_rows.push_back(r);
    endtask

    // directed light settings
    task automatic dir_light(input int sel);
        case (sel)
            1: set_light(MODE_DIR, 0, 0, -32'sd65536, 0, 0, 0, 16'sd16384);
            2: set_light(MODE_DIR_CONE, 0, 0, -32'sd65536, 0, 0, -16'sd16384, 16'sd11585);
            3: set_light(MODE_POINT, 0, 0, 32'sd655360, 0, 0, 0, 16'sd16384);
            4: set_light(MODE_POINT_CONE, 0, 0, 32'sd655360, 0, 0, -16'sd16384, -16'sd16384);
            default: set_light(3'd7, 32'h7fffffff, 32'h80000000, 0, 16'h7fff, 16'h8000, 0, 0);
        endcase
    endtask

    function automatic logic [15:0] rnd_normal();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(32768) - 16384);
    endfunction

    function automatic logic [31:0] rnd_q16(int span);
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(2 * span) - span);
        endcase
    endfunction

    initial
    begin
        int sel;
        int n_items;
        in_t it;
        out_t none_c;
        logic [2:0] mode_plan [11];
        logic [15:0] cs;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        typed_valid = 1'b0;
        typed_color = '0;
        n_errors = 0;
        n_colors = 0;
        send_idle_pct = 8;
        recv_idle_pct = 52;
        none_c = '0;
        lt_mode = MODE_NONE;
        lt_pos = '{0, 0, 0};
        lt_axis = '{0, 0, 0};
        lt_cos = 16384;
        mode_plan = '{MODE_DIR, MODE_DIR_CONE, MODE_POINT, MODE_POINT_CONE, MODE_NONE,
                      MODE_DIR_CONE, MODE_POINT_CONE, MODE_POINT, MODE_DIR, 3'd5, 3'd7};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state passes the color through
        add_row(0, mk_point(16'h7fff, 16'h8000, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff),
                1, 32'h7fffffff);
        add_row(0, mk_point(16'h8000, 0, 16'h7fff, 0, 0, 0, 32'h80000000, 32'h80000000),
                1, 32'h80000000);
        // head-on directional light, saturating both ways
        add_row(1, mk_point(0, 0, 16'sd16384, 0, 0, 0, 32'h7fffffff, 32'h7fffffff),
                1, 32'h7fffffff);
        add_row(1, mk_point(0, 0, 16'sd16384, 0, 0, 0, 32'h80000000, 32'h80000000),
                1, 32'h80000000);
        add_row(1, mk_point(0, 0, -16'sd16384, 0, 0, 0, 32'h00010000, 32'h00050000),
                1, 32'h00050000);
        add_row(1, mk_point(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 32'h00030000, 0), 0, 0);
        add_row(1, mk_point(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 32'h00030000, 0), 0, 0);
        // directional cone inside and outside
        add_row(2, mk_point(0, 0, -16'sd16384, 0, 0, 0, 32'h00020000, 32'h1000), 0, 0);
        add_row(2, mk_point(0, 0, 16'sd16384, 0, 0, 0, 32'h00020000, 32'h1000), 0, 0);
        add_row(2, mk_point(16'sd11585, 0, -16'sd11585, 0, 0, 0, 32'h00020000, 0), 0, 0);
        // point light: coincident point gives a zero vector
        add_row(3, mk_point(0, 0, 16'sd16384, 0, 0, 32'sd655360, 32'h7fffffff, 32'h1234),
                1, 32'h1234);
        add_row(3, mk_point(0, 0, 16'sd16384, 0, 0, 0, 32'h00010000, 0), 0, 0);
        add_row(3, mk_point(16'sd16384, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h7fffffff, 32'h40000000), 0, 0);
        add_row(3, mk_point(0, 16'sd16384, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            32'h80000000, 32'hc0000000), 0, 0);
        // point cone at the widest cosine
        add_row(4, mk_point(0, 0, 16'sd16384, 0, 0, 0, 32'h00010000, 0), 0, 0);
        add_row(4, mk_point(0, 0, 16'sd16384, 32'sd65536, 0, 0, 32'h00010000, 0), 0, 0);
        // unused mode passes the color through
        add_row(5, mk_point(0, 0, 16'sd16384, 0, 0, 0, 32'h7fffffff, 32'h5a5a5a5a),
                1, 32'h5a5a5a5a);

        sel = 0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_sel != sel)
            begin
                sel = dir_rows[i].cfg_sel;
                wait_drained();
                dir_light(sel);
            end
            send_point(dir_rows[i].item, dir_rows[i].has_color, dir_rows[i].color);
        end

        // random phases, one light setting each
        // the third phase is long so the receiver hold-off fills the pipeline
        for (int ph = 0; ph < 11; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 8;
            end
            if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n_items = (ph == 2) ? 100 : 45;
            wait_drained();
            case ($urandom_range(3))
                0: cs = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                default: cs = 16'($urandom_range(32768) - 16384);
            endcase
            if (ph >= 9)
                set_light(mode_plan[ph], $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom), 16'($urandom), cs);
            else
                set_light(mode_plan[ph], rnd_q16(20 << 16), rnd_q16(20 << 16),
                          rnd_q16(20 << 16), rnd_normal(), rnd_normal(), rnd_normal(), cs);
            for (int k = 0; k < n_items; k++)
            begin
                it.normal_x    = rnd_normal();
                it.normal_y    = rnd_normal();
                it.normal_z    = rnd_normal();
                it.point_x     = rnd_q16(20 << 16);
                it.point_y     = rnd_q16(20 << 16);
                it.point_z     = rnd_q16(20 << 16);
                it.light_red   = rnd_q16(4 << 16);
                it.light_green = rnd_q16(4 << 16);
                it.light_blue  = rnd_q16(4 << 16);
                it.sum_red     = rnd_q16(8 << 16);
                it.sum_green   = rnd_q16(8 << 16);
                it.sum_blue    = rnd_q16(8 << 16);
                send_point(it, 1'b0, none_c);
            end
        end

        // drain and finish
        in_valid <= 1'b0;
        @(posedge clk);
        while (color_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/ldl_pkg.sv
sv/ldl_vec.sv
sv/ldl_sqrt.sv
sv/ldl_div.sv
sv/ldl_shade.sv
sv/lambert_diffuse_light.sv
sim/tb_lambert_diffuse_light.sv
